/* src/bgr_pkg.sv */
// Shared constants, codes and helper functions of the button gesture recognizer.
package bgr_pkg;

   localparam int unsigned TimeWidth   = 17;
   localparam int unsigned CfgWidth    = 16;
   localparam int unsigned DtWidth     = 8;
   localparam int unsigned CountWidth  = 8;
   localparam int unsigned CsrIdxWidth = 8;
   localparam int unsigned ReqDataWidth = 16;
   localparam int unsigned RspDataWidth = 8;

   typedef logic [TimeWidth-1:0]  time_type;
   typedef logic [CfgWidth-1:0]   cfg_type;
   typedef logic [DtWidth-1:0]    dt_type;
   typedef logic [CountWidth-1:0] count_type;
   typedef logic [2:0]            gesture_type;

   // Register indexes of the configuration port.
   localparam logic [CsrIdxWidth-1:0] CSR_DEBOUNCE     = 8'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_PAIRING_HOLD = 8'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_MOMENT_MIN   = 8'd2;
   localparam logic [CsrIdxWidth-1:0] CSR_CLICK_WINDOW = 8'd3;

   // Reset values of the configuration registers, in milliseconds.
   localparam cfg_type DEBOUNCE_RESET     = 16'd30;
   localparam cfg_type PAIRING_HOLD_RESET = 16'd5000;
   localparam cfg_type MOMENT_MIN_RESET   = 16'd800;
   localparam cfg_type CLICK_WINDOW_RESET = 16'd400;

   // Gesture codes.
   localparam gesture_type EV_NONE      = 3'd0;
   localparam gesture_type EV_SINGLE    = 3'd1;
   localparam gesture_type EV_QUADRUPLE = 3'd4;
   localparam gesture_type EV_PAIRING   = 3'd5;
   localparam gesture_type EV_MOMENT    = 3'd6;

   localparam count_type COUNT_MAX = 8'd255;

   // Adds the tick length to a timer and clamps at the largest 17-bit value.
   function automatic time_type sat_add(time_type a, dt_type b);
      logic [TimeWidth:0] sum;
      sum = {1'b0, a} + {{(TimeWidth-DtWidth+1){1'b0}}, b};
      return sum[TimeWidth] ? {TimeWidth{1'b1}} : sum[TimeWidth-1:0];
   endfunction

   // Maps a click count to its gesture; five or more clicks give no event.
   function automatic gesture_type count_to_event(count_type n);
      gesture_type ev;
      ev = EV_NONE;
      if (n >= count_type'(EV_SINGLE) && n <= count_type'(EV_QUADRUPLE)) begin
         ev = n[2:0];
      end
      return ev;
   endfunction

endpackage

/* src/button_gesture_recognizer.sv */
// Top level of the button gesture recognizer: debounce, gesture state machine, result.
//
//   Channel  Direction  Payload (lowest bit first)          Transaction when
//   req_     in         raw_level, elapsed_ms               req_tvalid && req_tready
//   rsp_     out        gesture                             rsp_tvalid && rsp_tready
//   csr_     in         csr_index, csr_data                 csr_valid && csr_ready
//
// The debounce and state update are one pass of adders and comparators from the state
// registers into the result register, seen the next cycle.
// A tick is taken whenever the result register is empty or drained in the same cycle,
// so back-to-back ticks run at one per clock; a result held by a low rsp_tready blocks ticks.
// Reset is synchronous, active high, loads the default timing registers and marks the
// debounce counter as settled on the released level; register writes apply to the next tick.
module button_gesture_recognizer (
   input  logic        clock,
   input  logic        reset,
   // Input tick stream.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [0] raw_level, [8:1] elapsed_ms, [15:9] zero
   // Gesture result stream.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [2:0] gesture, [7:3] zero
   // Configuration writes.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [15:0] csr_data
);

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_PRESSED,
      PH_WINDOW,
      PH_RELEASE_WAIT
   } phase_type;

   // Timing registers.
   bgr_pkg::cfg_type debounce_ff, debounce_in;
   bgr_pkg::cfg_type pairing_ff, pairing_in;
   bgr_pkg::cfg_type moment_ff, moment_in;
   bgr_pkg::cfg_type window_cfg_ff, window_cfg_in;

   // Gesture state.
   phase_type           phase_ff, phase_in;
   logic                filtered_ff, filtered_in;
   logic                last_raw_ff, last_raw_in;
   bgr_pkg::time_type   stable_ff, stable_in;
   bgr_pkg::time_type   press_ff, press_in;
   bgr_pkg::time_type   window_ff, window_in;
   bgr_pkg::count_type  click_ff, click_in;

   // Result register.
   logic                 rsp_valid_ff, rsp_valid_in;
   bgr_pkg::gesture_type rsp_gesture_ff, rsp_gesture_in;

   logic                 raw;
   bgr_pkg::dt_type      dt;
   logic                 req_fire;
   logic                 csr_fire;
   bgr_pkg::time_type    debounce_ext;
   bgr_pkg::time_type    press_sum;
   bgr_pkg::time_type    window_sum;
   bgr_pkg::gesture_type gesture;

   assign raw          = req_tdata[0];
   assign dt           = req_tdata[8:1];
   assign req_tready   = !rsp_valid_ff || rsp_tready;
   assign req_fire     = req_tvalid && req_tready;
   assign csr_ready    = 1'b1;
   assign csr_fire     = csr_valid && csr_ready;
   assign debounce_ext = {1'b0, debounce_ff};
   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = {5'd0, rsp_gesture_ff};

   // Register file writes; an index past the last register is dropped.
   always_comb begin
      debounce_in   = debounce_ff;
      pairing_in    = pairing_ff;
      moment_in     = moment_ff;
      window_cfg_in = window_cfg_ff;
      if (csr_fire) begin
         unique case (csr_index)
            bgr_pkg::CSR_DEBOUNCE:     debounce_in   = csr_data;
            bgr_pkg::CSR_PAIRING_HOLD: pairing_in    = csr_data;
            bgr_pkg::CSR_MOMENT_MIN:   moment_in     = csr_data;
            bgr_pkg::CSR_CLICK_WINDOW: window_cfg_in = csr_data;
            default: ;
         endcase
      end
   end

   // One tick of debounce plus gesture phase update.
   always_comb begin
      last_raw_in = last_raw_ff;
      stable_in   = stable_ff;
      filtered_in = filtered_ff;
      phase_in    = phase_ff;
      press_in    = press_ff;
      window_in   = window_ff;
      click_in    = click_ff;
      gesture     = bgr_pkg::EV_NONE;
      press_sum   = bgr_pkg::sat_add(press_ff, dt);
      window_sum  = bgr_pkg::sat_add(window_ff, dt);

      // The stable counter only grows while short of the debounce time and
      // restarts on any change of the raw level.
      if (raw == last_raw_ff) begin
         if (stable_ff < debounce_ext) begin
            stable_in = bgr_pkg::sat_add(stable_ff, dt);
         end
      end else begin
         last_raw_in = raw;
         stable_in   = '0;
      end
      if (stable_in >= debounce_ext) begin
         filtered_in = last_raw_in;
      end

      unique case (phase_ff)
         PH_IDLE: begin
            if (filtered_in) begin
               click_in = bgr_pkg::count_type'(1);
               press_in = '0;
               phase_in = PH_PRESSED;
            end
         end
         PH_PRESSED: begin
            // The pairing check wins over a release on the same tick.
            press_in = press_sum;
            if (press_sum >= {1'b0, pairing_ff}) begin
               click_in = '0;
               press_in = {1'b0, pairing_ff};
               phase_in = PH_RELEASE_WAIT;
               gesture  = bgr_pkg::EV_PAIRING;
            end else if (!filtered_in) begin
               if (press_sum >= {1'b0, moment_ff}) begin
                  click_in = '0;
                  phase_in = PH_IDLE;
                  gesture  = bgr_pkg::EV_MOMENT;
               end else begin
                  window_in = '0;
                  phase_in  = PH_WINDOW;
               end
            end
         end
         PH_WINDOW: begin
            if (filtered_in) begin
               if (click_ff != bgr_pkg::COUNT_MAX) begin
                  click_in = click_ff + bgr_pkg::count_type'(1);
               end
               press_in = '0;
               phase_in = PH_PRESSED;
            end else begin
               window_in = window_sum;
               if (window_sum >= {1'b0, window_cfg_ff}) begin
                  gesture  = bgr_pkg::count_to_event(click_ff);
                  click_in = '0;
                  phase_in = PH_IDLE;
               end
            end
         end
         PH_RELEASE_WAIT: begin
            if (!filtered_in) begin
               phase_in = PH_IDLE;
            end
         end
         default: phase_in = PH_IDLE;
      endcase
   end

   // The result register fills on every accepted tick and empties when taken.
   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_gesture_in = rsp_gesture_ff;
      if (req_fire) begin
         rsp_valid_in   = 1'b1;
         rsp_gesture_in = gesture;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff   <= bgr_pkg::DEBOUNCE_RESET;
         pairing_ff    <= bgr_pkg::PAIRING_HOLD_RESET;
         moment_ff     <= bgr_pkg::MOMENT_MIN_RESET;
         window_cfg_ff <= bgr_pkg::CLICK_WINDOW_RESET;
         phase_ff      <= PH_IDLE;
         filtered_ff   <= 1'b0;
         last_raw_ff   <= 1'b0;
         stable_ff     <= {1'b0, bgr_pkg::DEBOUNCE_RESET};
         press_ff      <= '0;
         window_ff     <= '0;
         click_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         debounce_ff   <= debounce_in;
         pairing_ff    <= pairing_in;
         moment_ff     <= moment_in;
         window_cfg_ff <= window_cfg_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (req_fire) begin
            phase_ff    <= phase_in;
            filtered_ff <= filtered_in;
            last_raw_ff <= last_raw_in;
            stable_ff   <= stable_in;
            press_ff    <= press_in;
            window_ff   <= window_in;
            click_ff    <= click_in;
         end
      end
      rsp_gesture_ff <= rsp_gesture_in;
   end

`ifndef SYNTH
   // A pairing result always leaves the machine waiting for release.
   assert property (@(posedge clock) disable iff (reset)
      req_fire && gesture == bgr_pkg::EV_PAIRING |=> phase_ff == PH_RELEASE_WAIT)
      else $error("pairing did not move to release wait");

   // No clicks are pending once the machine is idle or waiting for release.
   assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_IDLE || phase_ff == PH_RELEASE_WAIT |-> click_ff == '0)
      else $error("click count left over outside a click sequence");

   // A press in progress always counts at least one click.
   assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PRESSED || phase_ff == PH_WINDOW |-> click_ff != '0)
      else $error("click sequence with zero clicks");

   // Ticks are only held off by a full result register that is not drained.
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_valid_ff && !rsp_tready)
      else $error("input stalled without a waiting result");
`endif

endmodule

/* tb/button_gesture_recognizer_checker.sv */
// Checker for the button gesture recognizer: watches all three channels, predicts and compares.
module button_gesture_recognizer_checker
   import bgr_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   input  logic                    req_tready,
   input  logic [ReqDataWidth-1:0] req_tdata,   // [0] raw_level, [8:1] elapsed_ms
   input  logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   input  logic [RspDataWidth-1:0] rsp_tdata,   // [2:0] gesture
   input  logic                    csr_valid,
   input  logic                    csr_ready,
   input  logic [CsrIdxWidth-1:0]  csr_index,
   input  logic [CfgWidth-1:0]     csr_data,
   output int                      mismatches,
   output int                      pending,
   output int                      checked,
   output int                      events
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PRESSED,
      ST_WINDOW,
      ST_RELEASE_WAIT
   } track_state_type;

   localparam int          REPORT_LIMIT = 10;
   localparam int unsigned TIME_LIMIT   = (1 << TimeWidth) - 1;

   cfg_type      debounce_cfg;
   cfg_type      pairing_cfg;
   cfg_type      moment_cfg;
   cfg_type      window_cfg;

   track_state_type track_state;
   logic         level_filtered;
   logic         level_last;
   time_type     stable_ms;
   time_type     press_ms;
   time_type     window_elapsed;
   count_type    clicks;

   gesture_type  gesture_queue[$];

   function automatic time_type clamp_add(time_type base, dt_type dt);
      int unsigned sum;
      sum = int'(base) + int'(dt);
      if (sum > TIME_LIMIT) begin
         return time_type'(TIME_LIMIT);
      end
      return time_type'(sum);
   endfunction

   function automatic gesture_type clicks_to_gesture(count_type n);
      if (n >= count_type'(EV_SINGLE) && n <= count_type'(EV_QUADRUPLE)) begin
         return gesture_type'(n);
      end
      return EV_NONE;
   endfunction

   // One tick of the debounce filter and the gesture machine.
   function automatic gesture_type advance_recognizer(logic raw, dt_type dt);
      gesture_type result;
      result = EV_NONE;
      if (raw == level_last) begin
         if (stable_ms < time_type'(debounce_cfg)) begin
            stable_ms = clamp_add(stable_ms, dt);
         end
      end else begin
         level_last = raw;
         stable_ms  = '0;
      end
      if (stable_ms >= time_type'(debounce_cfg)) begin
         level_filtered = level_last;
      end

      case (track_state)
         ST_IDLE: begin
            if (level_filtered) begin
               clicks      = count_type'(1);
               press_ms    = '0;
               track_state = ST_PRESSED;
            end
         end
         ST_PRESSED: begin
            press_ms = clamp_add(press_ms, dt);
            // The hold check wins over a release seen on the same tick.
            if (press_ms >= time_type'(pairing_cfg)) begin
               clicks      = '0;
               press_ms    = time_type'(pairing_cfg);
               track_state = ST_RELEASE_WAIT;
               result      = EV_PAIRING;
            end else if (!level_filtered) begin
               if (press_ms >= time_type'(moment_cfg)) begin
                  clicks      = '0;
                  track_state = ST_IDLE;
                  result      = EV_MOMENT;
               end else begin
                  window_elapsed = '0;
                  track_state    = ST_WINDOW;
               end
            end
         end
         ST_WINDOW: begin
            if (level_filtered) begin
               if (clicks != COUNT_MAX) begin
                  clicks = clicks + count_type'(1);
               end
               press_ms    = '0;
               track_state = ST_PRESSED;
            end else begin
               window_elapsed = clamp_add(window_elapsed, dt);
               if (window_elapsed >= time_type'(window_cfg)) begin
                  result      = clicks_to_gesture(clicks);
                  clicks      = '0;
                  track_state = ST_IDLE;
               end
            end
         end
         default: begin
            if (!level_filtered) begin
               track_state = ST_IDLE;
            end
         end
      endcase
      return result;
   endfunction

   // Sampling at the falling edge sees the values that the next rising edge acts on.
   always @(negedge clock) begin : watch
      gesture_type expected_gesture;
      gesture_type seen_gesture;
      if (reset) begin
         debounce_cfg   = DEBOUNCE_RESET;
         pairing_cfg    = PAIRING_HOLD_RESET;
         moment_cfg     = MOMENT_MIN_RESET;
         window_cfg     = CLICK_WINDOW_RESET;
         track_state    = ST_IDLE;
         level_filtered = 1'b0;
         level_last     = 1'b0;
         stable_ms      = time_type'(DEBOUNCE_RESET);
         press_ms       = '0;
         window_elapsed = '0;
         clicks         = '0;
         gesture_queue.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen_gesture = rsp_tdata[2:0];
            if (gesture_queue.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT) begin
                  $display("unexpected gesture %0d with no tick outstanding", seen_gesture);
               end
            end else begin
               expected_gesture = gesture_queue.pop_front();
               checked++;
               if (expected_gesture != EV_NONE) begin
                  events++;
               end
               if (seen_gesture !== expected_gesture) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT) begin
                     $display("gesture mismatch on result %0d: expected %0d, got %0d",
                              checked, expected_gesture, seen_gesture);
                  end
               end
            end
         end
         if (req_tvalid && req_tready) begin
            gesture_queue.push_back(advance_recognizer(req_tdata[0], req_tdata[DtWidth:1]));
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_DEBOUNCE:     debounce_cfg = csr_data;
               CSR_PAIRING_HOLD: pairing_cfg  = csr_data;
               CSR_MOMENT_MIN:   moment_cfg   = csr_data;
               CSR_CLICK_WINDOW: window_cfg   = csr_data;
               default: ;
            endcase
         end
      end
      pending = gesture_queue.size();
   end

endmodule

/* tb/button_gesture_recognizer_tb.sv */
// Testbench top of the button gesture recognizer: stimulus, idling, watchdog and verdict.
module button_gesture_recognizer_tb;
   import bgr_pkg::*;

   // Ways the two sides of the block idle during a phase.
   typedef enum int {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   // Cycles without any transaction on any channel before the run is given up.
   localparam int QUIET_LIMIT = 1000;

   // Register indexes outside the map; writes to them must leave every register alone.
   localparam logic [CsrIdxWidth-1:0] CSR_INDEX_PAST_END  = CSR_CLICK_WINDOW + CsrIdxWidth'(1);
   localparam logic [CsrIdxWidth-1:0] CSR_INDEX_ALL_ONES  = '1;

   logic                    clock      = 1'b0;
   logic                    reset      = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [ReqDataWidth-1:0] req_tdata  = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RspDataWidth-1:0] rsp_tdata;
   logic                    csr_valid  = 1'b0;
   logic                    csr_ready;
   logic [CsrIdxWidth-1:0]  csr_index  = '0;
   logic [CfgWidth-1:0]     csr_data   = '0;

   int mismatch_total;
   int pending;
   int checked_total;
   int event_total;

   // Stimulus shaping: the tick generator's own view of the timing registers.
   cfg_type debounce_ms;
   cfg_type pairing_ms;
   cfg_type moment_ms;
   cfg_type window_len;
   int      dt_ceiling  = 40;
   bit      long_ticks  = 1'b0;
   int      sender_pct  = 0;
   int      stall_pct   = 0;
   bit      sender_busy = 1'b0;
   int      ticks_sent  = 0;
   int      settings_used = 0;
   int      quiet_cycles  = 0;

   button_gesture_recognizer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   button_gesture_recognizer_checker gesture_check (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .mismatches (mismatch_total),
      .pending    (pending),
      .checked    (checked_total),
      .events     (event_total)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // The receiver drops rsp_tready at random, at the rate of the current phase.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // Watchdog: a stretch with no transaction anywhere means the block is stuck.
   always @(negedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("button_gesture_recognizer_tb failed");
         $finish;
      end
   end

   task automatic set_idling(input idle_mode_type mode);
      case (mode)
         IDLE_SENDER:   begin sender_pct = 69; stall_pct = 0;  end
         IDLE_RECEIVER: begin sender_pct = 0;  stall_pct = 69; end
         IDLE_BOTH:     begin sender_pct = 23; stall_pct = 23; end
         default:       begin sender_pct = 0;  stall_pct = 0;  end
      endcase
   endtask

   // Offers one tick and returns at the rising edge where its transaction happens.
   // Handshakes are judged at the falling edge, where every signal is settled.
   task automatic send_tick(input logic raw, input dt_type dt);
      if (sender_pct > 0 && $urandom_range(99) < sender_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < sender_pct);
      end
      req_tvalid  <= 1'b1;
      req_tdata   <= {{(ReqDataWidth - DtWidth - 1){1'b0}}, dt, raw};
      sender_busy  = 1'b1;
      do @(negedge clock); while (!req_tready);
      @(posedge clock);
      ticks_sent++;
   endtask

   // Stops offering ticks and waits until every gesture in flight has been taken.
   // The flag keeps a second call in the same step from assigning req_tvalid again.
   task automatic wait_drained();
      if (sender_busy) begin
         req_tvalid  <= 1'b0;
         sender_busy  = 1'b0;
      end
      while (pending != 0) @(posedge clock);
   endtask

   // csr_valid is left high so that writes can follow back to back; callers lower it.
   task automatic write_reg(input logic [CsrIdxWidth-1:0] index, input cfg_type value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(negedge clock); while (!csr_ready);
      @(posedge clock);
   endtask

   // Loads all four timing registers once the block has gone quiet.
   task automatic apply_setting(input cfg_type debounce, input cfg_type pairing,
                                input cfg_type moment, input cfg_type window);
      wait_drained();
      write_reg(CSR_DEBOUNCE, debounce);
      write_reg(CSR_PAIRING_HOLD, pairing);
      write_reg(CSR_MOMENT_MIN, moment);
      write_reg(CSR_CLICK_WINDOW, window);
      csr_valid  <= 1'b0;
      debounce_ms = debounce;
      pairing_ms  = pairing;
      moment_ms   = moment;
      window_len  = window;
      settings_used++;
   endtask

   // Tick lengths: mostly to the ceiling, 180 to 255 with long_ticks, at times any byte.
   function automatic dt_type pick_dt();
      if ($urandom_range(99) < 5) begin
         return dt_type'($urandom_range(255));
      end
      if (long_ticks) begin
         return dt_type'($urandom_range(255, 180));
      end
      return dt_type'($urandom_range(dt_ceiling));
   endfunction

   // Holds the raw level for at least the given number of milliseconds.
   task automatic hold_level(input logic level, input int ms);
      int held;
      held = 0;
      do begin
         dt_type dt;
         dt = pick_dt();
         send_tick(level, dt);
         held += int'(dt);
      end while (held < ms);
   endtask

   // Contact bounce: short flips that the debounce filter should mostly swallow.
   task automatic bounce();
      repeat ($urandom_range(3, 1)) begin
         send_tick(1'b1, dt_type'($urandom_range(7)));
         send_tick(1'b0, dt_type'($urandom_range(7)));
      end
   endtask

   // Press length aimed at one of the three outcomes: click, moment or pairing.
   function automatic int press_length();
      int roll;
      roll = $urandom_range(99);
      if (roll < 70) begin
         return $urandom_range(moment_ms > 0 ? int'(moment_ms) - 1 : 0);
      end
      if (roll < 85) begin
         return $urandom_range(int'(pairing_ms), int'(moment_ms));
      end
      return int'(pairing_ms) + $urandom_range(300);
   endfunction

   // A run of presses; the gaps stay inside the click window except after the last.
   task automatic play_clicks(input int count);
      int gap;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(3) == 0) begin
            bounce();
         end
         hold_level(1'b1, int'(debounce_ms) + press_length());
         if (i == count - 1) begin
            gap = int'(window_len) + $urandom_range(100);
         end else begin
            gap = $urandom_range(window_len > 0 ? int'(window_len) - 1 : 0);
         end
         hold_level(1'b0, int'(debounce_ms) + gap);
      end
   endtask

   task automatic play_noise();
      repeat ($urandom_range(16, 4)) begin
         send_tick(1'($urandom_range(1)), pick_dt());
      end
   endtask

   // Mostly well-formed gestures with random content, some noise, the odd full drain.
   task automatic run_gestures(input int budget);
      int first_tick;
      int roll;
      int count;
      first_tick = ticks_sent;
      while (ticks_sent - first_tick < budget) begin
         roll = $urandom_range(99);
         if (roll < 15) begin
            play_noise();
         end else begin
            count = $urandom_range(6, 1);
            if ($urandom_range(9) == 0) begin
               count = $urandom_range(10, 7);
            end
            play_clicks(count);
         end
         if (roll >= 97) begin
            wait_drained();
         end
      end
   endtask

   initial begin : stimulus
      cfg_type pairing_pick;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: at the reset timing, idle ticks at both tick-length extremes, then a
      // press held long enough for a moment, where the release is filtered first.
      send_tick(1'b0, dt_type'(0));
      send_tick(1'b0, '1);
      send_tick(1'b1, dt_type'(0));
      repeat (4) send_tick(1'b1, '1);
      send_tick(1'b0, '1);
      send_tick(1'b0, '1);

      // Zero debounce makes the filter follow the raw level. A release on the same tick
      // as the pairing hold is reached must still report pairing. Writes to indexes past
      // the register map must change nothing.
      wait_drained();
      write_reg(CSR_DEBOUNCE, '0);
      write_reg(CSR_PAIRING_HOLD, cfg_type'(300));
      write_reg(CSR_CLICK_WINDOW, cfg_type'(1));
      write_reg(CSR_INDEX_ALL_ONES, '1);
      write_reg(CSR_INDEX_PAST_END, '0);
      csr_valid <= 1'b0;
      send_tick(1'b1, dt_type'(0));
      send_tick(1'b1, '1);
      send_tick(1'b0, dt_type'(45));
      send_tick(1'b0, dt_type'(0));
      // Two quick clicks closed by a one-millisecond window.
      send_tick(1'b1, dt_type'(0));
      send_tick(1'b0, dt_type'(0));
      send_tick(1'b1, dt_type'(0));
      send_tick(1'b0, dt_type'(0));
      send_tick(1'b0, dt_type'(1));

      // Random gestures at the reset timing.
      set_idling(IDLE_NONE);
      apply_setting(DEBOUNCE_RESET, PAIRING_HOLD_RESET, MOMENT_MIN_RESET, CLICK_WINDOW_RESET);
      dt_ceiling = 255;
      run_gestures(150);

      // Short random timings so that many gestures complete, cycling the idling modes.
      for (int p = 0; p < 4; p++) begin
         set_idling(idle_mode_type'(p % 4));
         pairing_pick = cfg_type'($urandom_range(1500, 200));
         apply_setting(cfg_type'($urandom_range(20)), pairing_pick,
                       cfg_type'($urandom_range(1600, 50)), cfg_type'($urandom_range(300, 20)));
         dt_ceiling = $urandom_range(60, 8);
         run_gestures(120);
      end

      // All registers at zero: every press turns into pairing right away.
      set_idling(IDLE_BOTH);
      apply_setting('0, '0, '0, '0);
      dt_ceiling = 3;
      run_gestures(80);

      // More than 255 clicks in one window: the count must stick at its maximum
      // instead of wrapping back into the one-to-four range.
      set_idling(IDLE_SENDER);
      apply_setting('0, '1, cfg_type'(2000), cfg_type'(2000));
      repeat (260) begin
         send_tick(1'b1, dt_type'($urandom_range(3)));
         send_tick(1'b0, dt_type'($urandom_range(3)));
      end
      dt_ceiling = 255;
      hold_level(1'b0, 2100);

      // All registers at their maximum: one press held through the longest debounce
      // and the longest pairing hold, with long ticks to keep the run short.
      set_idling(IDLE_RECEIVER);
      apply_setting('1, '1, '1, '1);
      long_ticks = 1'b1;
      hold_level(1'b1, int'(debounce_ms) + 300);
      hold_level(1'b0, int'(debounce_ms) + 300);
      long_ticks = 1'b0;

      wait_drained();
      // Give a stray result from the block time to show up.
      repeat (4) @(posedge clock);

      $display("covered %0d ticks under %0d timing settings plus directed writes",
               ticks_sent, settings_used);
      $display("%0d gestures checked, %0d of them non-empty events, %0d mismatches",
               checked_total, event_total, mismatch_total);
      if (mismatch_total == 0) begin
         $display("button_gesture_recognizer_tb passed");
      end else begin
         $display("button_gesture_recognizer_tb failed");
      end
      $finish;
   end

endmodule

/* filelist.f */
src/bgr_pkg.sv
src/button_gesture_recognizer.sv
tb/button_gesture_recognizer_checker.sv
tb/button_gesture_recognizer_tb.sv
